/* rtl/utc_pkg.sv */
// constants and types shared by the utf-8 text classifier
`timescale 1ns / 1ps
package utc_pkg;

    localparam int COUNT_WIDTH   = 32;
    localparam int TOL_FRAC_BITS = 16;
    localparam int TOL_WIDTH     = TOL_FRAC_BITS + 1;
    localparam int PROD_WIDTH    = COUNT_WIDTH + TOL_WIDTH;

    localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(6554);

    localparam logic [7:0] PRINT_LO  = 8'h20;
    localparam logic [7:0] PRINT_HI  = 8'h7E;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] ASCII_MAX = 8'h7F;
    localparam logic [7:0] CONT_LO   = 8'h80;
    localparam logic [7:0] CONT_HI   = 8'hBF;
    localparam logic [7:0] LEAD2_LO  = 8'hC0;
    localparam logic [7:0] LEAD2_HI  = 8'hDF;
    localparam logic [7:0] LEAD3_LO  = 8'hE0;
    localparam logic [7:0] LEAD3_HI  = 8'hEF;
    localparam logic [7:0] LEAD4_LO  = 8'hF0;
    localparam logic [7:0] LEAD4_HI  = 8'hF7;
    localparam logic [10:0] CP2_MIN  = 11'h0A0;

    localparam logic [1:0] NEED_NONE = 2'd0;
    localparam logic [1:0] NEED_ONE  = 2'd1;
    localparam logic [1:0] NEED_TWO  = 2'd2;
    localparam logic [1:0] NEED_THREE = 2'd3;

    typedef struct packed {
        logic [COUNT_WIDTH-1:0] total;
        logic [COUNT_WIDTH-1:0] nonprint;
    } t_counts;

endpackage

/* rtl/utf8_text_classifier_top.sv */
// utf-8 text classifier: byte stream in, text verdict and unit counts per buffer out
// result: counts are registered in the fin stage, then verdict and counts in the out stage
// throughput: one byte per cycle; the end-of-buffer multiply sits in its own stage
// a byte is held back only while a finished result waits behind a stalled output
// reset: sequence state and counters clear, tolerance returns to 6554
`timescale 1ns / 1ps
module utf8_text_classifier_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [utc_pkg::TOL_WIDTH-1:0]     i_cfg_data,
    output logic                              o_cfg_ready,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_data_byte,
    input  logic                              i_last_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_text_verdict,
    output logic [utc_pkg::COUNT_WIDTH-1:0]   o_unit_count,
    output logic [utc_pkg::COUNT_WIDTH-1:0]   o_nonprint_count
);
    import utc_pkg::*;

    logic [TOL_WIDTH-1:0]   r_tol;
    logic                   r_in_valid;
    logic [7:0]             r_in_byte;
    logic                   r_in_last;
    logic [7:0]             r_lead;
    logic [1:0]             r_need;
    logic [1:0]             r_seen;
    t_counts                r_cnt;
    logic                   r_fin_valid;
    t_counts                r_fin;
    logic                   r_out_valid;
    logic                   r_out_verdict;
    t_counts                r_out;

    logic [7:0]             n_lead;
    logic [1:0]             n_need;
    logic [1:0]             n_seen;
    t_counts                n_cnt;
    logic [2:0]             inc_t;
    logic [2:0]             inc_n;
    logic [2:0]             seen_p1;
    logic [10:0]            cp2;
    logic                   taken;
    logic                   is_cont;
    logic                   ascii_pr;
    logic [COUNT_WIDTH:0]   sum_t;
    logic [COUNT_WIDTH:0]   sum_n;
    logic [PROD_WIDTH-1:0]  prod;
    logic [COUNT_WIDTH:0]   limit;
    logic                   verdict;

    logic                   ready_out;
    logic                   ready_fin;
    logic                   a_consume;
    logic                   ready_in;

    // handshake between stages
    assign ready_out   = !r_out_valid || !i_out_stall;
    assign ready_fin   = !r_fin_valid || ready_out;
    assign a_consume   = r_in_valid && (!r_in_last || ready_fin);
    assign ready_in    = !r_in_valid || a_consume;
    assign o_in_stall  = !ready_in;
    assign o_cfg_ready = 1'b1;

    // per-byte sequence tracking and count increments
    always_comb begin
        n_lead   = r_lead;
        n_need   = r_need;
        n_seen   = r_seen;
        inc_t    = 3'd0;
        inc_n    = 3'd0;
        taken    = 1'b0;
        seen_p1  = {1'b0, r_seen} + 3'd1;
        cp2      = {r_lead[4:0], r_in_byte[5:0]};
        is_cont  = r_in_byte inside {[CONT_LO:CONT_HI]};
        ascii_pr = r_in_byte inside {[PRINT_LO:PRINT_HI], CH_TAB, CH_LF, CH_CR};
        if (r_need != NEED_NONE) begin
            if (is_cont) begin
                taken = 1'b1;
                if (seen_p1 >= {1'b0, r_need}) begin
                    inc_t  = 3'd1;
                    inc_n  = {2'b00, (r_need == NEED_ONE) && (cp2 < CP2_MIN)};
                    n_need = NEED_NONE;
                    n_seen = 2'd0;
                    n_lead = 8'h00;
                end else begin
                    n_seen = seen_p1[1:0];
                end
            end else begin
                // broken sequence: lead plus taken continuations
                inc_t  = seen_p1;
                inc_n  = seen_p1;
                n_need = NEED_NONE;
                n_seen = 2'd0;
                n_lead = 8'h00;
            end
        end
        if (!taken) begin
            if (r_in_byte <= ASCII_MAX) begin
                inc_t = inc_t + 3'd1;
                inc_n = inc_n + {2'b00, !ascii_pr};
            end else if (r_in_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
                n_lead = r_in_byte;
                n_need = NEED_ONE;
                n_seen = 2'd0;
            end else if (r_in_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
                n_lead = r_in_byte;
                n_need = NEED_TWO;
                n_seen = 2'd0;
            end else if (r_in_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
                n_lead = r_in_byte;
                n_need = NEED_THREE;
                n_seen = 2'd0;
            end else begin
                inc_t = inc_t + 3'd1;
                inc_n = inc_n + 3'd1;
            end
        end
        // flush a sequence left open at end of buffer
        if (r_in_last && (n_need != NEED_NONE)) begin
            inc_t = inc_t + {1'b0, n_seen} + 3'd1;
            inc_n = inc_n + {1'b0, n_seen} + 3'd1;
        end
        sum_t = {1'b0, r_cnt.total} + (COUNT_WIDTH + 1)'(inc_t);
        sum_n = {1'b0, r_cnt.nonprint} + (COUNT_WIDTH + 1)'(inc_n);
        n_cnt.total    = sum_t[COUNT_WIDTH] ? '1 : sum_t[COUNT_WIDTH-1:0];
        n_cnt.nonprint = sum_n[COUNT_WIDTH] ? '1 : sum_n[COUNT_WIDTH-1:0];
    end

    // verdict: nonprint < floor(total * tolerance)
    assign prod    = PROD_WIDTH'(r_fin.total) * PROD_WIDTH'(r_tol);
    assign limit   = prod[PROD_WIDTH-1:TOL_FRAC_BITS];
    assign verdict = {1'b0, r_fin.nonprint} < limit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tol       <= TOL_RESET;
            r_in_valid  <= 1'b0;
            r_lead      <= 8'h00;
            r_need      <= NEED_NONE;
            r_seen      <= 2'd0;
            r_cnt       <= '0;
            r_fin_valid <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_tol <= i_cfg_data;
            end
            if (ready_in) begin
                r_in_valid <= i_in_valid;
            end
            if (a_consume) begin
                if (r_in_last) begin
                    r_lead <= 8'h00;
                    r_need <= NEED_NONE;
                    r_seen <= 2'd0;
                    r_cnt  <= '0;
                end else begin
                    r_lead <= n_lead;
                    r_need <= n_need;
                    r_seen <= n_seen;
                    r_cnt  <= n_cnt;
                end
            end
            if (ready_fin) begin
                r_fin_valid <= a_consume && r_in_last;
            end
            if (ready_out) begin
                r_out_valid <= r_fin_valid;
            end
        end
    end

    // payload words
    always_ff @(posedge i_clk) begin
        if (ready_in && i_in_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last_byte;
        end
        if (ready_fin && a_consume && r_in_last) begin
            r_fin <= n_cnt;
        end
        if (ready_out && r_fin_valid) begin
            r_out_verdict <= verdict;
            r_out         <= r_fin;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_text_verdict   = r_out_verdict;
    assign o_unit_count     = r_out.total;
    assign o_nonprint_count = r_out.nonprint;

endmodule
